// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every edge outside reset
`define KSSB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kssb assertion failed");

// Checked at every edge, reset included
`define KSSB_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("kssb assertion failed");

`else

`define KSSB_ASSERT(name, prop)
`define KSSB_ASSERT_ALWAYS(name, prop)

`endif

`endif

// ----- rtl/kssb_pkg.sv -----
// Package: sizes, codes and transaction types of the shared-buffer stacks.
`timescale 1ns / 1ps
package kssb_pkg;

  localparam int unsigned Slots     = 64;
  localparam int unsigned Stacks    = 8;
  localparam int unsigned DataW     = 32;
  localparam int unsigned StackIdW  = 3;
  localparam int unsigned LinkW     = 7;
  localparam int unsigned SlotW     = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned StackIdxW = (Stacks > 1) ? $clog2(Stacks) : 1;
  localparam int unsigned WalkLimit = (Slots < 64) ? Slots : 64;
  localparam int unsigned CntW      = $clog2(WalkLimit + 1);

  localparam logic [LinkW-1:0] NullLink = '1;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_DISPLAY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVER  = 2'd1,
    STAT_UNDER = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic [StackIdW-1:0]        stack_id;
    logic signed [DataW-1:0]    value;
  } in_item_t;

  typedef struct packed {
    status_e                    status;
    logic signed [DataW-1:0]    data;
    logic                       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch the transaction, start the first slot read
    logic exec;    // perform the operation and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
    logic walk_more;  // display has further elements after this one
  } dp_status_t;

  function automatic logic link_ok(logic [LinkW-1:0] l);
    return 32'(l) < Slots;
  endfunction

  // Link held by a slot that has not been written since reset
  function automatic logic [LinkW-1:0] reset_link(logic [SlotW-1:0] s);
    logic [31:0] nxt;
    nxt = 32'(s) + 32'd1;
    if (nxt < Slots) begin
      return LinkW'(nxt);
    end
    return NullLink;
  endfunction

endpackage

// ----- rtl/k_stacks_shared_buffer.sv -----
// Top level: several stacks in one shared slot store with a free list.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Input channel in_valid_i / in_ready_o carries one operation per
//   transaction: push, pop, peek or display on a chosen stack.
//   Output channel out_valid_o / out_ready_i carries results; the last
//   field marks the final result of an operation.
//   Push, pop and peek: one result, registered in the execute step once
//   the result register is free; no new operation is taken before it.
//   Display of n elements: n results, one per cycle while the receiver
//   takes them; an empty stack gives one underflow result.
//   Each step reads the link and value memories once (registered read),
//   and the walk follows one link per cycle while results are taken.
//   One operation is in flight at a time; in_ready_o is low meanwhile.
//   A stalled receiver holds the result register; the block waits with
//   it and resumes as soon as the result is taken.
//   Reset empties every stack and chains all slots into the free list;
//   no clearing pass is needed, the block is ready at once.
module k_stacks_shared_buffer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kssb_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kssb_pkg::out_item_t out_item_o
);

  kssb_pkg::cmd_t       cmd;
  kssb_pkg::dp_status_t status;

  kssb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  kssb_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // an accepted transaction always owns the block for the next cycle
  `KSSB_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // a result is never produced over one the receiver has not taken
  `KSSB_ASSERT(a_no_overwrite, cmd.exec |-> (!out_valid_o || out_ready_i))
  // a display walk with more elements keeps the input closed
  `KSSB_ASSERT(a_walk_holds, (cmd.exec && status.walk_more) |=> !in_ready_o)

endmodule

// ----- rtl/kssb_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module kssb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                      clk_i,
  input  logic                                      wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                          wr_data_i,
  input  logic                                      rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                          rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- rtl/kssb_ctrl.sv -----
// Controller: sequences accept and execute steps of each transaction.
`timescale 1ns / 1ps
module kssb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kssb_pkg::dp_status_t status_i,
  output kssb_pkg::cmd_t      cmd_o
);

  kssb_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kssb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kssb_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = kssb_pkg::S_EXEC;
        end
      end
      kssb_pkg::S_EXEC: begin
        // a display walk stays here, one element per free output slot
        if (status_i.out_free && !status_i.walk_more) begin
          state_d = kssb_pkg::S_IDLE;
        end
      end
      default: state_d = kssb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.accept = 1'b0;
    cmd_o.exec   = 1'b0;
    case (state_q)
      kssb_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      kssb_pkg::S_EXEC: begin
        cmd_o.exec = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/kssb_dpath.sv -----
// Datapath: slot memories, free list, stack tops and result register.
`timescale 1ns / 1ps
module kssb_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kssb_pkg::in_item_t   in_item_i,
  input  kssb_pkg::cmd_t       cmd_i,
  output kssb_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kssb_pkg::out_item_t  out_item_o
);

  // transaction in flight
  kssb_pkg::opcode_e                op_q;
  logic [kssb_pkg::StackIdW-1:0]    sn_q;
  logic [kssb_pkg::DataW-1:0]       val_q;
  logic [kssb_pkg::LinkW-1:0]       cur_q;
  logic                             err_q;
  logic [kssb_pkg::CntW-1:0]        cnt_q;

  // list state
  logic [kssb_pkg::LinkW-1:0]       free_head_q;
  logic [kssb_pkg::LinkW-1:0]       stack_top_q [kssb_pkg::Stacks];
  logic [kssb_pkg::Slots-1:0]       link_vld_q;
  logic                             rd_vld_q;
  logic [kssb_pkg::SlotW-1:0]       rd_addr_q;

  kssb_pkg::out_item_t              out_q, out_d;
  logic                             out_valid_q;

  logic [kssb_pkg::LinkW-1:0]       in_top, in_cur, cur_top, link_eff, link_rd;
  logic                             in_sn_ok, in_err, fin, walk_more;
  logic [kssb_pkg::StackIdxW-1:0]   in_idx, sn_idx;
  logic                             rd_en;
  logic [kssb_pkg::SlotW-1:0]       rd_addr;
  logic                             link_we, val_we;
  logic [kssb_pkg::LinkW-1:0]       link_wdata;
  logic [kssb_pkg::DataW-1:0]       val_rd;

  // ---- accept side
  assign in_idx   = kssb_pkg::StackIdxW'(in_item_i.stack_id);
  assign in_sn_ok = 32'(in_item_i.stack_id) < kssb_pkg::Stacks;
  assign in_top   = in_sn_ok ? stack_top_q[in_idx] : kssb_pkg::NullLink;
  assign in_cur   = (in_item_i.opcode == kssb_pkg::OP_PUSH) ? free_head_q : in_top;
  assign in_err   = (in_item_i.opcode == kssb_pkg::OP_PUSH) ?
                    (!in_sn_ok || !kssb_pkg::link_ok(free_head_q)) :
                    !kssb_pkg::link_ok(in_top);

  // ---- execute side
  assign sn_idx  = kssb_pkg::StackIdxW'(sn_q);
  assign cur_top = stack_top_q[sn_idx];

  // slots never written still hold their reset chain
  assign link_eff = rd_vld_q ? link_rd : kssb_pkg::reset_link(rd_addr_q);

  assign fin       = !kssb_pkg::link_ok(link_eff) ||
                     ((32'(cnt_q) + 32'd1) >= kssb_pkg::WalkLimit);
  assign walk_more = (op_q == kssb_pkg::OP_DISPLAY) && !err_q && !fin;

  assign status_o.walk_more = walk_more;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign rd_en   = cmd_i.accept || (cmd_i.exec && walk_more);
  assign rd_addr = cmd_i.accept ? in_cur[kssb_pkg::SlotW-1:0]
                                : link_eff[kssb_pkg::SlotW-1:0];

  always_comb begin
    link_we    = 1'b0;
    val_we     = 1'b0;
    link_wdata = cur_top;
    if (cmd_i.exec && !err_q) begin
      case (op_q)
        kssb_pkg::OP_PUSH: begin
          link_we    = 1'b1;
          val_we     = 1'b1;
          link_wdata = cur_top;
        end
        kssb_pkg::OP_POP: begin
          link_we    = 1'b1;
          link_wdata = free_head_q;
        end
        default: begin
          link_we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    out_d.status = kssb_pkg::STAT_OK;
    out_d.data   = '0;
    out_d.last   = 1'b1;
    if (err_q) begin
      out_d.status = (op_q == kssb_pkg::OP_PUSH) ? kssb_pkg::STAT_OVER
                                                 : kssb_pkg::STAT_UNDER;
    end else begin
      case (op_q)
        kssb_pkg::OP_PUSH:    out_d.data = '0;
        kssb_pkg::OP_DISPLAY: begin
          out_d.data = val_rd;
          out_d.last = fin;
        end
        default:              out_d.data = val_rd;
      endcase
    end
  end

  kssb_ram #(
    .Width(kssb_pkg::LinkW),
    .Depth(kssb_pkg::Slots)
  ) u_link_ram (
    .clk_i    (clk_i),
    .wr_en_i  (link_we),
    .wr_addr_i(cur_q[kssb_pkg::SlotW-1:0]),
    .wr_data_i(link_wdata),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(link_rd)
  );

  kssb_ram #(
    .Width(kssb_pkg::DataW),
    .Depth(kssb_pkg::Slots)
  ) u_value_ram (
    .clk_i    (clk_i),
    .wr_en_i  (val_we),
    .wr_addr_i(cur_q[kssb_pkg::SlotW-1:0]),
    .wr_data_i(val_q),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(val_rd)
  );

  // ---- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      for (int i = 0; i < kssb_pkg::Stacks; i++) begin
        stack_top_q[i] <= kssb_pkg::NullLink;
      end
      link_vld_q  <= '0;
      rd_vld_q    <= 1'b0;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_q  <= link_vld_q[rd_addr];
        rd_addr_q <= rd_addr;
      end
      if (link_we) begin
        link_vld_q[cur_q[kssb_pkg::SlotW-1:0]] <= 1'b1;
      end
      if (cmd_i.exec && !err_q) begin
        case (op_q)
          kssb_pkg::OP_PUSH: begin
            free_head_q         <= link_eff;
            stack_top_q[sn_idx] <= cur_q;
          end
          kssb_pkg::OP_POP: begin
            free_head_q         <= cur_q;
            stack_top_q[sn_idx] <= link_eff;
          end
          default: begin
            free_head_q <= free_head_q;
          end
        endcase
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= in_item_i.opcode;
      sn_q  <= in_item_i.stack_id;
      val_q <= in_item_i.value;
      cur_q <= in_cur;
      err_q <= in_err;
      cnt_q <= '0;
    end else if (cmd_i.exec && walk_more) begin
      cur_q <= link_eff;
      cnt_q <= cnt_q + kssb_pkg::CntW'(1);
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- bench/k_stacks_shared_buffer_tb.sv -----
// Testbench: stack operations on the shared-slot stacks, predicted and checked per result.
`timescale 1ns / 1ps
module k_stacks_shared_buffer_tb;
  import kssb_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  k_stacks_shared_buffer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  int        mismatches = 0;
  int        cycle_cnt = 0;
  logic      quiet;

  // Long stretch with no idling on either side
  assign quiet = (cycle_cnt >= 300) && (cycle_cnt < 800);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the slot store, links, stack tops and free list
  // ---------------------------------------------------------------------------
  logic signed [DataW-1:0] slot_data [Slots];
  logic [LinkW-1:0]        slot_next [Slots];
  logic [LinkW-1:0]        top_slot  [Stacks];
  logic [LinkW-1:0]        free_slot;

  function automatic bit is_slot(logic [LinkW-1:0] l);
    return 32'(l) < Slots;
  endfunction

  function automatic out_item_t mk_result(status_e st, logic [DataW-1:0] d, logic lst);
    out_item_t r;
    r.status = st;
    r.data   = d;
    r.last   = lst;
    return r;
  endfunction

  task automatic clear_stacks();
    for (int i = 0; i < Slots; i++) begin
      slot_data[i] = '0;
      slot_next[i] = (i + 1 < Slots) ? LinkW'(i + 1) : NullLink;
    end
    for (int i = 0; i < Stacks; i++) begin
      top_slot[i] = NullLink;
    end
    free_slot = '0;
  endtask

  task automatic model_stack_op(in_item_t it);
    logic [LinkW-1:0] t;
    logic [LinkW-1:0] cur;
    logic [LinkW-1:0] nxt;
    logic [LinkW-1:0] slot;
    int               n;
    int               walk_max;
    bit               fin;
    t = (32'(it.stack_id) < Stacks) ? top_slot[it.stack_id] : NullLink;
    if (it.opcode == OP_PUSH) begin
      if (32'(it.stack_id) >= Stacks || !is_slot(free_slot)) begin
        expected_results.push_back(mk_result(STAT_OVER, '0, 1'b1));
      end else begin
        slot = free_slot;
        free_slot = slot_next[slot];
        slot_next[slot] = t;
        top_slot[it.stack_id] = slot;
        slot_data[slot] = it.value;
        expected_results.push_back(mk_result(STAT_OK, '0, 1'b1));
      end
    end else if (!is_slot(t)) begin
      expected_results.push_back(mk_result(STAT_UNDER, '0, 1'b1));
    end else if (it.opcode == OP_POP) begin
      expected_results.push_back(mk_result(STAT_OK, slot_data[t], 1'b1));
      top_slot[it.stack_id] = slot_next[t];
      slot_next[t] = free_slot;
      free_slot = t;
    end else if (it.opcode == OP_PEEK) begin
      expected_results.push_back(mk_result(STAT_OK, slot_data[t], 1'b1));
    end else begin
      walk_max = (Slots < 64) ? Slots : 64;
      n = 0;
      cur = t;
      while (is_slot(cur) && n < walk_max) begin
        nxt = slot_next[cur];
        fin = !is_slot(nxt) || (n + 1 >= walk_max);
        expected_results.push_back(mk_result(STAT_OK, slot_data[cur], fin));
        n++;
        cur = nxt;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 10);
      if (in_valid && in_ready) begin
        model_stack_op(in_item);
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && (quiet || $urandom_range(99) >= 10)) begin
          in_valid <= 1'b1;
          in_item  <= pending_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: status %0d data %h last %0d",
                   out_item.status, out_item.data, out_item.last);
        end
      end else begin
        want = expected_results.pop_front();
        if (out_item.status !== want.status || out_item.data !== want.data ||
            out_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected status %0d data %h last %0d, got %0d %h %0d",
                     want.status, want.data, want.last,
                     out_item.status, out_item.data, out_item.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int gen_depth[Stacks];
  int gen_used = 0;

  // Queue one operation and track occupancy so the sequence can be steered
  task automatic add_op(opcode_e op, int sid, logic [DataW-1:0] v);
    in_item_t it;
    it.opcode   = op;
    it.stack_id = StackIdW'(sid);
    it.value    = v;
    pending_ops.push_back(it);
    if (op == OP_PUSH && gen_used < Slots && sid < Stacks) begin
      gen_depth[sid]++;
      gen_used++;
    end else if (op == OP_POP && sid < Stacks && gen_depth[sid] > 0) begin
      gen_depth[sid]--;
      gen_used--;
    end
  endtask

  initial begin
    int target;
    int sid;
    int r;
    clear_stacks();
    for (int i = 0; i < Stacks; i++) begin
      gen_depth[i] = 0;
    end

    // Directed: empty stacks, extreme values, slot reuse
    add_op(OP_POP,     0, $urandom());
    add_op(OP_PEEK,    7, $urandom());
    add_op(OP_DISPLAY, 0, $urandom());
    add_op(OP_PUSH,    0, 32'h7fff_ffff);
    add_op(OP_PUSH,    0, 32'h8000_0000);
    add_op(OP_PUSH,    7, 32'h0000_0000);
    add_op(OP_PUSH,    0, 32'hffff_ffff);
    add_op(OP_PEEK,    0, $urandom());
    add_op(OP_DISPLAY, 0, $urandom());
    add_op(OP_DISPLAY, 7, $urandom());
    add_op(OP_POP,     7, $urandom());
    add_op(OP_POP,     7, $urandom());
    add_op(OP_PEEK,    7, $urandom());
    add_op(OP_POP,     0, $urandom());
    add_op(OP_POP,     0, $urandom());
    add_op(OP_POP,     0, $urandom());
    add_op(OP_DISPLAY, 0, $urandom());
    add_op(OP_PUSH,    5, 32'ha5a5_a5a5);
    add_op(OP_PUSH,    2, 32'h5a5a_5a5a);
    add_op(OP_POP,     2, $urandom());
    add_op(OP_DISPLAY, 5, $urandom());
    add_op(OP_POP,     5, $urandom());

    // Fill every slot into one stack, so the walk covers the whole store
    target = $urandom_range(Stacks - 1);
    while (gen_used < Slots) begin
      r = $urandom_range(99);
      sid = $urandom_range(Stacks - 1);
      if (r < 85) begin
        add_op(OP_PUSH, target, $urandom());
      end else if (r < 90) begin
        add_op(OP_PEEK, sid, $urandom());
      end else if (r < 95) begin
        add_op(OP_DISPLAY, sid, $urandom());
      end else begin
        add_op(OP_POP, sid, $urandom());
      end
    end
    add_op(OP_DISPLAY, target, $urandom());
    add_op(OP_PUSH, target, $urandom());
    add_op(OP_PUSH, (target + 1) % Stacks, $urandom());
    add_op(OP_PEEK, target, $urandom());

    // Mixed traffic: freed slots move to other stacks
    for (int i = 0; i < 28; i++) begin
      r = $urandom_range(99);
      sid = $urandom_range(1) ? target : $urandom_range(Stacks - 1);
      if (r < 40) begin
        add_op(OP_POP, sid, $urandom());
      end else if (r < 70) begin
        add_op(OP_PUSH, sid, $urandom());
      end else if (r < 85) begin
        add_op(OP_PEEK, sid, $urandom());
      end else begin
        add_op(OP_DISPLAY, sid, $urandom());
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("k_stacks_shared_buffer test passed");
    end else begin
      $display("k_stacks_shared_buffer test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("k_stacks_shared_buffer test failed");
    $finish;
  end

endmodule
